// ===== src/plt_pkg.sv =====
// Shared types and constants of the protocol line tokenizer.
package plt_pkg;

    localparam int PLT_LINE_CAPACITY = 512;
    localparam int PLT_MAX_TOKENS    = 16;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_LINE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MODE_SPLIT   = 2'd0,
        MODE_COLON   = 2'd1,
        MODE_DISCARD = 2'd2
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [3:0]  token_index;
        logic [4:0]  token_count;
    } t_result;

endpackage

// ===== src/plt_if.sv =====
// Valid/ready channel interfaces for received bytes and tokenizer results.
interface plt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface plt_tok_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [3:0] token_index;
    logic [4:0] token_count;

    modport source (output valid, output kind, output data_byte, output token_index,
                    output token_count, input ready);
    modport sink (input valid, input kind, input data_byte, input token_index,
                  input token_count, output ready);
endinterface

// ===== src/plt_parse.sv =====
// Input register, line state and per-byte tokenizing decision logic.
module plt_parse #(
    parameter int LINE_CAPACITY = plt_pkg::PLT_LINE_CAPACITY,
    parameter int MAX_TOKENS    = plt_pkg::PLT_MAX_TOKENS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    plt_byte_if.sink          i_rx,
    output logic              o_res_valid,
    output plt_pkg::t_result  o_res,
    input  logic              i_res_ready
);

    localparam int LW = $clog2(LINE_CAPACITY + 1);
    localparam int PW = $clog2(MAX_TOKENS + 1);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;

    logic [LW-1:0]        r_line_length, n_line_length;
    logic [PW-1:0]        r_param_count, n_param_count;
    plt_pkg::t_mode       r_parse_mode, n_parse_mode;
    logic                 r_token_empty, n_token_empty;
    logic                 r_line_has_text, n_line_has_text;

    logic                 has_res;
    logic                 fire;
    logic                 in_ready;
    logic [PW-1:0]        cnt;
    logic [PW-1:0]        pc_inc;
    logic [31:0]          cnt_ext;
    plt_pkg::t_result     res;

    assign fire     = r_in_valid && (!has_res || i_res_ready);
    assign in_ready = !r_in_valid || fire;
    assign i_rx.ready = in_ready;

    assign o_res_valid = r_in_valid && has_res;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_rx.valid;
        end
        if (in_ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length   <= '0;
            r_param_count   <= '0;
            r_parse_mode    <= plt_pkg::MODE_SPLIT;
            r_token_empty   <= 1'b1;
            r_line_has_text <= 1'b0;
        end else if (fire) begin
            r_line_length   <= n_line_length;
            r_param_count   <= n_param_count;
            r_parse_mode    <= n_parse_mode;
            r_token_empty   <= n_token_empty;
            r_line_has_text <= n_line_has_text;
        end
    end

    always_comb begin
        n_line_length   = r_line_length;
        n_param_count   = r_param_count;
        n_parse_mode    = r_parse_mode;
        n_token_empty   = r_token_empty;
        n_line_has_text = r_line_has_text;
        has_res         = 1'b0;
        res.kind        = plt_pkg::KIND_BYTE;
        res.data_byte   = 8'h00;
        res.token_index = 4'(r_param_count);
        res.token_count = 5'd0;
        pc_inc          = r_param_count + PW'(1);
        cnt             = pc_inc;
        cnt_ext         = 32'(cnt);

        if (r_in_byte == plt_pkg::CHAR_NUL) begin
            has_res = 1'b0;
        end else if (r_in_byte == plt_pkg::CHAR_LF || r_in_byte == plt_pkg::CHAR_CR) begin
            if (r_line_has_text) begin
                if (r_parse_mode == plt_pkg::MODE_SPLIT ||
                    r_parse_mode == plt_pkg::MODE_COLON) begin
                    cnt = pc_inc;
                end else begin
                    cnt = r_param_count;
                end
                cnt_ext         = 32'(cnt);
                has_res         = 1'b1;
                res.kind        = plt_pkg::KIND_LINE;
                res.token_index = 4'(cnt_ext - 32'd1);
                res.token_count = 5'(cnt_ext);
            end
            n_line_length   = '0;
            n_param_count   = '0;
            n_parse_mode    = plt_pkg::MODE_SPLIT;
            n_token_empty   = 1'b1;
            n_line_has_text = 1'b0;
        end else if (r_line_length < LW'(LINE_CAPACITY)) begin
            n_line_length   = r_line_length + LW'(1);
            n_line_has_text = 1'b1;
            case (r_parse_mode)
                plt_pkg::MODE_COLON: begin
                    has_res       = 1'b1;
                    res.data_byte = r_in_byte;
                end
                plt_pkg::MODE_SPLIT: begin
                    has_res = 1'b1;
                    if (r_in_byte == plt_pkg::CHAR_SPACE) begin
                        res.kind      = plt_pkg::KIND_END;
                        n_param_count = pc_inc;
                        n_token_empty = 1'b1;
                        if (pc_inc >= PW'(MAX_TOKENS)) begin
                            n_parse_mode = plt_pkg::MODE_DISCARD;
                        end
                    end else begin
                        if (r_token_empty && r_param_count != '0 &&
                            r_in_byte == plt_pkg::CHAR_COLON) begin
                            n_parse_mode = plt_pkg::MODE_COLON;
                        end
                        n_token_empty = 1'b0;
                        res.data_byte = r_in_byte;
                    end
                end
                default: begin
                    has_res = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== src/plt_out_reg.sv =====
// Result register driving the output channel.
module plt_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  plt_pkg::t_result  i_res,
    output logic              o_res_ready,
    plt_tok_if.source         o_tok
);

    logic              r_valid;
    plt_pkg::t_result  r_res;
    logic              load;

    assign o_res_ready = !r_valid || o_tok.ready;
    assign load        = i_res_valid && o_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
        if (load) begin
            r_res <= i_res;
        end
    end

    assign o_tok.valid       = r_valid;
    assign o_tok.kind        = r_res.kind;
    assign o_tok.data_byte   = r_res.data_byte;
    assign o_tok.token_index = r_res.token_index;
    assign o_tok.token_count = r_res.token_count;

endmodule

// ===== src/protocol_line_tokenizer_top.sv =====
// An accepted byte goes through the input register and then the result register before its result is valid.
// Throughput: one byte per cycle; a result held at the output stalls the input register.
// Bytes that give no result (NUL, dropped, discarded) retire without using the output.
// Reset: synchronous active-low i_rst_n clears channel valids and line state.
// No memory, so no clearing pass after reset.
module protocol_line_tokenizer_top #(
    parameter int LINE_CAPACITY = plt_pkg::PLT_LINE_CAPACITY,
    parameter int MAX_TOKENS    = plt_pkg::PLT_MAX_TOKENS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plt_byte_if.sink    i_rx,
    plt_tok_if.source   o_tok
);

    logic              res_valid;
    logic              res_ready;
    plt_pkg::t_result  res;

    plt_parse #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .MAX_TOKENS    (MAX_TOKENS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    plt_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_tok       (o_tok)
    );

    a_line_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid && o_tok.kind == plt_pkg::KIND_LINE |->
            o_tok.token_index == 4'(o_tok.token_count - 5'd1))
        else $error("line end index does not match count");

    a_count_only_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid && o_tok.kind != plt_pkg::KIND_LINE |-> o_tok.token_count == 5'd0)
        else $error("count set on non line-end transaction");

    a_data_only_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid && o_tok.kind != plt_pkg::KIND_BYTE |-> o_tok.data_byte == 8'h00)
        else $error("data set on marker transaction");

    a_byte_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid && o_tok.kind == plt_pkg::KIND_BYTE |->
            o_tok.data_byte != plt_pkg::CHAR_NUL && o_tok.data_byte != plt_pkg::CHAR_CR &&
            o_tok.data_byte != plt_pkg::CHAR_LF)
        else $error("NUL or line terminator emitted as parameter byte");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> res.kind != 2'd3)
        else $error("illegal result kind");

endmodule

// ===== test/tb_token_board_pkg.sv =====
// Scoreboard class: line tokenizer predictor and result checker.
`timescale 1ns / 100ps
package tb_token_board_pkg;
    import plt_pkg::*;

    class token_board;
        t_result     expected_tokens[$];
        int          mismatches;
        int          line_len;
        logic [4:0]  closed_params;
        t_mode       mode;
        bit          token_empty;
        bit          line_has_text;

        function new();
            mismatches = 0;
            clear_line();
        endfunction

        function void clear_line();
            line_len      = 0;
            closed_params = 5'd0;
            mode          = MODE_SPLIT;
            token_empty   = 1'b1;
            line_has_text = 1'b0;
        endfunction

        function void push_token(t_kind kind, logic [7:0] data, logic [4:0] idx,
                                 logic [4:0] cnt);
            t_result r;
            r.kind        = kind;
            r.data_byte   = data;
            r.token_index = idx[3:0];
            r.token_count = cnt;
            expected_tokens.push_back(r);
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        // Predict the token output caused by one accepted byte.
        function void note_byte(logic [7:0] b);
            logic [4:0] cnt;
            if (b == CHAR_NUL) return;
            if (b == CHAR_LF || b == CHAR_CR) begin
                if (line_has_text) begin
                    cnt = (mode == MODE_SPLIT || mode == MODE_COLON) ?
                          closed_params + 5'd1 : closed_params;
                    push_token(KIND_LINE, 8'h00, cnt - 5'd1, cnt);
                end
                clear_line();
                return;
            end
            if (line_len >= PLT_LINE_CAPACITY) return;
            line_len++;
            line_has_text = 1'b1;
            if (mode == MODE_COLON) begin
                push_token(KIND_BYTE, b, closed_params, 5'd0);
                return;
            end
            if (mode != MODE_SPLIT) return;
            if (b == CHAR_SPACE) begin
                push_token(KIND_END, 8'h00, closed_params, 5'd0);
                closed_params++;
                token_empty = 1'b1;
                if (closed_params >= PLT_MAX_TOKENS) mode = MODE_DISCARD;
                return;
            end
            // colon opens a trailing parameter, never in the first one
            if (token_empty && closed_params != 5'd0 && b == CHAR_COLON) mode = MODE_COLON;
            token_empty = 1'b0;
            push_token(KIND_BYTE, b, closed_params, 5'd0);
        endfunction

        function void check_token(t_result got);
            t_result want;
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token: kind %0d byte %02h idx %0d cnt %0d",
                             got.kind, got.data_byte, got.token_index, got.token_count);
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind != want.kind || got.data_byte != want.data_byte ||
                    got.token_index != want.token_index ||
                    got.token_count != want.token_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"token mismatch: exp kind %0d byte %02h idx %0d cnt %0d, ",
                              "got kind %0d byte %02h idx %0d cnt %0d"},
                             want.kind, want.data_byte, want.token_index, want.token_count,
                             got.kind, got.data_byte, got.token_index, got.token_count);
            end
        endfunction
    endclass

endpackage

// ===== test/tb_top.sv =====
// Top-level testbench of the protocol line tokenizer.
`timescale 1ns / 100ps
module tb_top;
    import plt_pkg::*;
    import tb_token_board_pkg::*;

    localparam int ITEM_GOAL      = 2000;
    localparam int CALM_TAIL      = 250;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LONG_LINE_LEN  = 520;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm = 1'b0;
    int   bytes_sent = 0;
    int   stall_left = 0;
    int   idle_cycles = 0;
    token_board board;

    plt_byte_if rx_if();
    plt_tok_if  tok_if();

    protocol_line_tokenizer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_tok   (tok_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver side: random ready-low bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            tok_if.ready  <= (stall_left == 1);
        end else if (!calm && i_rst_n && $urandom_range(0, 11) == 0) begin
            stall_left    <= $urandom_range(1, 15);
            tok_if.ready  <= 1'b0;
        end else begin
            tok_if.ready  <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready) board.note_byte(rx_if.rx_byte);
            if (tok_if.valid && tok_if.ready) begin
                got.kind        = t_kind'(tok_if.kind);
                got.data_byte   = tok_if.data_byte;
                got.token_index = tok_if.token_index;
                got.token_count = tok_if.token_count;
                board.check_token(got);
            end
            if ((rx_if.valid && rx_if.ready) || (tok_if.valid && tok_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 7) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        bytes_sent++;
        if (bytes_sent >= ITEM_GOAL - CALM_TAIL) calm = 1'b1;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == CHAR_LF || c == CHAR_CR || c == CHAR_SPACE) c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    task automatic send_terminator();
        case ($urandom_range(0, 3))
            0: send_byte(CHAR_LF);
            1: send_byte(CHAR_CR);
            2: begin
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            default: begin
                send_byte(CHAR_LF);
                send_byte(CHAR_LF);
            end
        endcase
    endtask

    // line past the capacity, either as one word or behind a colon parameter
    task automatic send_long_line(input bit with_colon);
        if (with_colon) send_text("a :");
        repeat (LONG_LINE_LEN) begin
            if (with_colon && $urandom_range(0, 5) == 0) send_byte(CHAR_SPACE);
            else send_byte(word_char());
        end
        send_terminator();
    endtask

    task automatic send_random_line();
        int pick;
        int nparams;
        int len;
        pick = $urandom_range(0, 199);
        if (pick < 2) begin
            send_long_line(pick[0]);
        end else if (pick < 42) begin
            len = $urandom_range(0, 24);
            repeat (len) send_byte(8'($urandom_range(0, 255)));
            send_byte(CHAR_LF);
        end else begin
            nparams = (pick < 72) ? $urandom_range(14, 22) : $urandom_range(1, 6);
            for (int p = 0; p < nparams; p++) begin
                if (p != 0) send_byte(CHAR_SPACE);
                if ($urandom_range(0, 7) == 0) begin
                    send_byte(CHAR_COLON);
                    len = $urandom_range(0, 10);
                    repeat (len) send_byte(($urandom_range(0, 4) == 0) ? CHAR_SPACE
                                                                       : word_char());
                end else begin
                    len = $urandom_range(0, 6);
                    repeat (len) send_byte(word_char());
                end
            end
            if ($urandom_range(0, 9) == 0) send_byte(CHAR_NUL);
            send_terminator();
        end
    endtask

    initial begin
        board         = new();
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        tok_if.ready  = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty line, NUL, leading colon, double space, colon tail, extremes
        send_byte(CHAR_LF);
        send_byte(CHAR_NUL);
        send_text(":a b");
        send_byte(CHAR_LF);
        send_text("x  :c d");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(CHAR_CR);

        bytes_sent = 0;
        send_long_line(1'b1);
        while (bytes_sent < ITEM_GOAL) send_random_line();
        rx_if.valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/plt_pkg.sv
src/plt_if.sv
src/plt_parse.sv
src/plt_out_reg.sv
src/protocol_line_tokenizer_top.sv
test/tb_token_board_pkg.sv
test/tb_top.sv
